// ===== rtl/vzz_pkg.sv =====
// ----------------------------------------------------------------------------
// Varint zigzag codec package
// Shared request types, status structs and constants of the codec.
// ----------------------------------------------------------------------------
package vzz_pkg;

	// Width of one base-128 data group.
	localparam int unsigned DIGIT_W = 7;
	// Number of groups that fit entirely in 32 bits.
	localparam int unsigned FULL_GROUPS = 4;
	// Group index at which the decoder saturates (bit position 35).
	localparam logic [2:0] LAST_GROUP = 3'd5;
	// Group index whose data straddles bit 31.
	localparam logic [2:0] SPLIT_GROUP = 3'd4;
	// Saturation value of the decoded byte count.
	localparam logic [3:0] COUNT_MAX = 4'd15;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_DIRECTION = 2'd0;
	localparam logic [1:0] REG_SIGNED    = 2'd1;

	// Direction codes.
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// One input request.
	typedef struct packed {
		logic [31:0] value_in;
		logic [7:0]  byte_in;
	} in_item_t;

	// One result request.
	typedef struct packed {
		logic [7:0]  byte_out;
		logic        last;
		logic [31:0] value_out;
		logic [3:0]  byte_count;
		logic        overflow;
	} out_item_t;

	// Status of the encoder shift unit toward the top level.
	typedef struct packed {
		logic       busy;
		logic [7:0] byte_out;
		logic       last;
	} enc_status_t;

endpackage

// ===== rtl/vzz_enc.sv =====
// ----------------------------------------------------------------------------
// Varint encoder shift unit
// Holds the (zigzag mapped) value in a shift register and emits one 7-bit
// group per advance, least significant group first.
// ----------------------------------------------------------------------------
module vzz_enc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [31:0]          value,
	input  logic                 signed_mode,
	input  logic                 advance,
	output vzz_pkg::enc_status_t status
);

	logic        busy_q;
	logic [31:0] shift_q;
	logic [31:0] rest;
	logic        last;

	// Remaining groups after the current one; the run ends when none are left.
	assign rest = {7'd0, shift_q[31:vzz_pkg::DIGIT_W]};
	assign last = (rest == 32'd0);

	assign status.busy     = busy_q;
	assign status.last     = last;
	assign status.byte_out = {~last, shift_q[vzz_pkg::DIGIT_W-1:0]};

	// Busy flag: set on load, cleared when the final group leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (advance && last) begin
			busy_q <= 1'b0;
		end
	end

	// Shift register, loaded with the zigzag mapped value when signed.
	always_ff @(posedge clk) begin
		if (load) begin
			if (signed_mode) begin
				shift_q <= {value[30:0], 1'b0} ^ {32{value[31]}};
			end else begin
				shift_q <= value;
			end
		end else if (advance) begin
			shift_q <= rest;
		end
	end

endmodule

// ===== rtl/vzz_dec.sv =====
// ----------------------------------------------------------------------------
// Varint decoder accumulator
// Places each incoming 7-bit group at its group position and produces the
// finished value when a byte with a clear top bit arrives.
// ----------------------------------------------------------------------------
module vzz_dec (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               strobe,
	input  logic [7:0]         byte_in,
	input  logic               signed_mode,
	output logic               done,
	output vzz_pkg::out_item_t result
);

	logic [31:0] acc_q;
	logic [2:0]  group_q;
	logic [3:0]  count_q;
	logic        lost_q;

	logic [31:0] acc_d;
	logic [2:0]  group_d;
	logic [3:0]  count_d;
	logic        lost_d;
	logic [6:0]  data;

	assign data = byte_in[vzz_pkg::DIGIT_W-1:0];
	assign done = strobe && !byte_in[7];

	// Next accumulator state for the incoming group.
	always_comb begin
		acc_d   = acc_q;
		lost_d  = lost_q;
		group_d = group_q;
		for (int g = 0; g < vzz_pkg::FULL_GROUPS; g++) begin
			if (group_q == 3'(g)) begin
				acc_d[g*vzz_pkg::DIGIT_W +: vzz_pkg::DIGIT_W] =
					acc_q[g*vzz_pkg::DIGIT_W +: vzz_pkg::DIGIT_W] | data;
			end
		end
		// The fifth group keeps only four bits; the rest are dropped.
		if (group_q == vzz_pkg::SPLIT_GROUP) begin
			acc_d[31:28] = acc_q[31:28] | data[3:0];
			if (data[6:4] != 3'd0) begin
				lost_d = 1'b1;
			end
		end
		// Beyond bit 35 every nonzero group is lost.
		if (group_q == vzz_pkg::LAST_GROUP) begin
			if (data != 7'd0) begin
				lost_d = 1'b1;
			end
		end else begin
			group_d = group_q + 3'd1;
		end
		if (count_q == vzz_pkg::COUNT_MAX) begin
			count_d = count_q;
		end else begin
			count_d = count_q + 4'd1;
		end
	end

	// Finished value, un-zigzagged when signed.
	always_comb begin
		result            = '0;
		result.last       = 1'b1;
		result.byte_count = count_d;
		result.overflow   = lost_d;
		if (signed_mode) begin
			result.value_out = {1'b0, acc_d[31:1]} ^ {32{acc_d[0]}};
		end else begin
			result.value_out = acc_d;
		end
	end

	// Running state; cleared after a value completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			group_q <= '0;
			count_q <= '0;
			lost_q  <= 1'b0;
		end else if (strobe) begin
			if (done) begin
				acc_q   <= '0;
				group_q <= '0;
				count_q <= '0;
				lost_q  <= 1'b0;
			end else begin
				acc_q   <= acc_d;
				group_q <= group_d;
				count_q <= count_d;
				lost_q  <= lost_d;
			end
		end
	end

endmodule

// ===== rtl/varint_zigzag_codec.sv =====
// Encode: a value is taken, then its 1 to 5 bytes leave the shift register
// one per cycle while the single output register is free; no new value is
// taken before the last byte leaves. Decode: one byte per cycle while that
// register is free; a value appears there in the cycle after its final byte.
// Reset clears configuration, decoder state and the output valid flag.
// ----------------------------------------------------------------------------
// Varint zigzag codec
// Base-128 varint encoder and decoder with optional zigzag signed mapping.
// ----------------------------------------------------------------------------
module varint_zigzag_codec (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  vzz_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output vzz_pkg::out_item_t out_data
);

	logic                 dir_q;
	logic                 signed_q;
	logic                 out_valid_q;
	vzz_pkg::out_item_t   out_q;

	logic                 in_accept;
	logic                 slot_free;
	logic                 enc_load;
	logic                 enc_advance;
	logic                 dec_strobe;
	logic                 dec_done;
	vzz_pkg::enc_status_t enc_status;
	vzz_pkg::out_item_t   dec_result;
	vzz_pkg::out_item_t   enc_item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= vzz_pkg::DIR_ENCODE;
			signed_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				vzz_pkg::REG_DIRECTION: dir_q    <= cfg_data;
				vzz_pkg::REG_SIGNED:    signed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input handshake. The output slot frees when empty or being taken.
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = enc_status.busy ||
		((dir_q == vzz_pkg::DIR_DECODE) && !slot_free);
	assign in_accept   = in_valid && !in_stall;
	assign enc_load    = in_accept && (dir_q == vzz_pkg::DIR_ENCODE);
	assign dec_strobe  = in_accept && (dir_q == vzz_pkg::DIR_DECODE);
	assign enc_advance = enc_status.busy && slot_free;

	vzz_enc u_enc (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (enc_load),
		.value       (in_data.value_in),
		.signed_mode (signed_q),
		.advance     (enc_advance),
		.status      (enc_status)
	);

	vzz_dec u_dec (
		.clk         (clk),
		.arst_n      (arst_n),
		.strobe      (dec_strobe),
		.byte_in     (in_data.byte_in),
		.signed_mode (signed_q),
		.done        (dec_done),
		.result      (dec_result)
	);

	// Encoded byte request; the decode fields stay zero.
	always_comb begin
		enc_item          = '0;
		enc_item.byte_out = enc_status.byte_out;
		enc_item.last     = enc_status.last;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (enc_advance || dec_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (enc_advance) begin
			out_q <= enc_item;
		end else if (dec_done) begin
			out_q <= dec_result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	// No new request is taken while the encoder still has bytes to emit.
	assert property (@(posedge clk) disable iff (!arst_n)
		enc_status.busy |-> in_stall)
		else $error("request accepted while encoder busy");

	// A continuation byte is always followed by more bytes from the encoder.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last) |-> enc_status.busy)
		else $error("continuation byte without pending encoder run");

	// Encoder and decoder never compete for the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(enc_advance && dec_done))
		else $error("encoder and decoder load output together");

	// Decoded results carry no byte and a nonzero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.byte_count != 4'd0) |-> (out_q.byte_out == 8'd0))
		else $error("decoded result carries an encoded byte");
`endif

endmodule

// ===== bench/varint_zigzag_codec_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Varint zigzag codec testbench
// Sends encode values and decode bytes under changing flow control. A small
// scoreboard predicts every result, and the bench compares each accepted
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module varint_zigzag_codec_tb;

	// Register indexes that the codec does not decode.
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	localparam int ITEMS_PER_PHASE = 46;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 80;

	// Scoreboard: mirrors the codec state and holds the results still owed.
	class codec_predictor;
		logic                dir_reg;
		logic                zigzag_en;
		logic [31:0]         partial_value;
		logic [5:0]          shift_pos;
		logic [3:0]          byte_tally;
		logic                dropped_bits;
		vzz_pkg::out_item_t  owed_results[$];
		int unsigned         mismatches;

		function new();
			dir_reg = vzz_pkg::DIR_ENCODE;
			zigzag_en = 1'b0;
			mismatches = 0;
			clear_partial();
		endfunction

		function void clear_partial();
			partial_value = '0;
			shift_pos = '0;
			byte_tally = '0;
			dropped_bits = 1'b0;
		endfunction

		// Register writes; indexes the codec does not know change nothing.
		function void write_register(logic [1:0] idx, logic data);
			if (idx == vzz_pkg::REG_DIRECTION)
				dir_reg = data;
			else if (idx == vzz_pkg::REG_SIGNED)
				zigzag_en = data;
		endfunction

		function int unsigned pending();
			return owed_results.size();
		endfunction

		// Works out the results that one accepted request causes.
		function void predict_request(vzz_pkg::in_item_t req);
			vzz_pkg::out_item_t res;
			logic [31:0]        v;
			logic [6:0]         grp;
			logic [6:0]         data;
			if (dir_reg == vzz_pkg::DIR_ENCODE) begin
				v = req.value_in;
				if (zigzag_en)
					v = {v[30:0], 1'b0} ^ {32{v[31]}};
				// Seven bits per byte, least significant group first.
				do begin
					grp = v[6:0];
					v = v >> vzz_pkg::DIGIT_W;
					res = '0;
					res.byte_out = {(v != 0), grp};
					res.last = (v == 0);
					owed_results.push_back(res);
				end while (v != 0);
			end else begin
				data = req.byte_in[6:0];
				// Bits landing above bit 31 are dropped and remembered.
				if (shift_pos < 6'd32) begin
					partial_value = partial_value | ({25'd0, data} << shift_pos);
					if (shift_pos > 6'd25 && (({25'd0, data} >> (6'd32 - shift_pos)) != 0))
						dropped_bits = 1'b1;
					shift_pos = shift_pos + 6'd7;
					if (shift_pos > 6'd35)
						shift_pos = 6'd35;
				end else if (data != 0) begin
					dropped_bits = 1'b1;
				end
				if (byte_tally != vzz_pkg::COUNT_MAX)
					byte_tally = byte_tally + 4'd1;
				// A clear top bit closes the value.
				if (!req.byte_in[7]) begin
					v = partial_value;
					if (zigzag_en)
						v = (v >> 1) ^ {32{v[0]}};
					res = '0;
					res.last = 1'b1;
					res.value_out = v;
					res.byte_count = byte_tally;
					res.overflow = dropped_bits;
					owed_results.push_back(res);
					clear_partial();
				end
			end
		endfunction

		function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
			if (exp_val !== act_val) begin
				$error("%s: expected %0h, got %0h", name, exp_val, act_val);
				mismatches++;
			end
		endfunction

		// Compares one accepted result with the oldest prediction.
		function void check_result(vzz_pkg::out_item_t got);
			vzz_pkg::out_item_t exp_res;
			if (owed_results.size() == 0) begin
				$error("result: expected none, got %0h", got);
				mismatches++;
			end else begin
				exp_res = owed_results.pop_front();
				compare_field("byte_out", 32'(exp_res.byte_out), 32'(got.byte_out));
				compare_field("last", 32'(exp_res.last), 32'(got.last));
				compare_field("value_out", exp_res.value_out, got.value_out);
				compare_field("byte_count", 32'(exp_res.byte_count), 32'(got.byte_count));
				compare_field("overflow", 32'(exp_res.overflow), 32'(got.overflow));
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic               cfg_data;
	logic               in_valid;
	logic               in_stall;
	vzz_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_stall;
	vzz_pkg::out_item_t out_data;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_request = 1'b0;

	codec_predictor predictor = new();

	varint_zigzag_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off when asked.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			predictor.check_result(out_data);
	end

	// Offers one request, after random idle cycles, and waits until it is taken.
	task automatic send_request(input vzz_pkg::in_item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predictor.predict_request(req);
	endtask

	task automatic send_value(input logic [31:0] v);
		vzz_pkg::in_item_t req;
		req.value_in = v;
		req.byte_in = 8'($urandom_range(255));
		send_request(req);
	endtask

	task automatic send_byte(input logic [7:0] b);
		vzz_pkg::in_item_t req;
		req.value_in = $urandom;
		req.byte_in = b;
		send_request(req);
	endtask

	// One varint of the given length with random data groups.
	task automatic send_varint_bytes(input int len);
		logic [6:0] data;
		for (int i = 0; i < len; i++) begin
			data = 7'($urandom_range(127));
			if (i == vzz_pkg::FULL_GROUPS && $urandom_range(3) != 0)
				data = 7'($urandom_range(15));
			if (i > vzz_pkg::FULL_GROUPS && $urandom_range(1) == 1)
				data = '0;
			send_byte({(i != len - 1), data});
		end
	endtask

	// Waits until every owed result has arrived and the codec has gone quiet.
	task automatic settle();
		while (predictor.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stops offering, lets the codec drain, then writes both registers and a
	// spare index that must be ignored.
	task automatic reconfigure(input logic dir, input logic zigzag);
		logic [1:0] spare;
		logic       spare_data;
		spare = ($urandom_range(1) == 1) ? REG_SPARE_HI : REG_SPARE_LO;
		spare_data = 1'($urandom_range(1));
		in_valid <= 1'b0;
		settle();
		cfg_we <= 1'b1;
		cfg_index <= vzz_pkg::REG_DIRECTION;
		cfg_data <= dir;
		@(posedge clk);
		predictor.write_register(vzz_pkg::REG_DIRECTION, dir);
		cfg_index <= vzz_pkg::REG_SIGNED;
		cfg_data <= zigzag;
		@(posedge clk);
		predictor.write_register(vzz_pkg::REG_SIGNED, zigzag);
		cfg_index <= spare;
		cfg_data <= spare_data;
		@(posedge clk);
		predictor.write_register(spare, spare_data);
		cfg_we <= 1'b0;
	endtask

	// Encode values of every length, with small negative numbers in the mix.
	function automatic logic [31:0] random_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(3))
			0: begin
				v = v >> $urandom_range(31);
			end
			1: begin
				v = ~(v >> $urandom_range(31));
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	// Main sequence.
	initial begin
		int   sent;
		int   run_len;
		int   pick;
		int   idle_mode;
		logic dir_sel;
		logic zig_sel;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= vzz_pkg::REG_DIRECTION;
		cfg_data <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings encode unsigned; zero gives one zero byte.
		send_value(32'h0000_0000);
		send_value(32'h0000_007F);
		send_value(32'h0000_0080);
		send_value(32'hFFFF_FFFF);

		// Zigzag extremes.
		reconfigure(vzz_pkg::DIR_ENCODE, 1'b1);
		send_value(32'h0000_0000);
		send_value(32'hFFFF_FFFF);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);

		// Decode: a zero byte, the largest value, and over-long input that
		// drops bits both in the straddling group and beyond bit 35.
		reconfigure(vzz_pkg::DIR_DECODE, 1'b0);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h0F);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(8'hF0);
		send_byte(8'h01);

		// Mode switch mid-value: the partial value resumes after encoding,
		// and the signed setting at the final byte applies.
		send_byte(8'h85);
		reconfigure(vzz_pkg::DIR_ENCODE, 1'b1);
		send_value(32'hFFFF_FFFE);
		reconfigure(vzz_pkg::DIR_DECODE, 1'b1);
		send_byte(8'h03);

		// Random phases over every setting and idling pattern.
		for (int p = 0; p < 8; p++) begin
			dir_sel = (p % 2 == 1) ? vzz_pkg::DIR_DECODE : vzz_pkg::DIR_ENCODE;
			zig_sel = ((p / 2) % 2 == 1);
			reconfigure(dir_sel, zig_sel);
			idle_mode = (p + p / 4) % 4;
			case (idle_mode)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 68;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 68;
				end
				default: begin
					send_idle_pct = 28;
					recv_stall_pct = 28;
				end
			endcase
			// Long receiver hold-off so the codec backs up into its input.
			if (p == 0)
				hold_request = 1'b1;
			sent = 0;
			if (dir_sel == vzz_pkg::DIR_DECODE) begin
				// Long enough to saturate the byte count.
				send_varint_bytes(17);
				sent = 17;
			end
			while (sent < ITEMS_PER_PHASE) begin
				if (dir_sel == vzz_pkg::DIR_ENCODE) begin
					send_value(random_value());
					sent++;
				end else begin
					pick = $urandom_range(99);
					if (pick < 70)
						run_len = $urandom_range(5, 1);
					else if (pick < 85)
						run_len = $urandom_range(18, 6);
					else
						run_len = 0;
					if (run_len == 0) begin
						send_byte(8'($urandom_range(255)));
						sent++;
					end else begin
						send_varint_bytes(run_len);
						sent += run_len;
					end
				end
			end
		end

		in_valid <= 1'b0;
		settle();
		if (predictor.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/vzz_pkg.sv
rtl/vzz_enc.sv
rtl/vzz_dec.sv
rtl/varint_zigzag_codec.sv
bench/varint_zigzag_codec_tb.sv
